>>> rtl/lsmt_pkg.sv
// Shared types and constants of the LCD scan mode timer.
// Word layouts, the one-hot mode type, register indexes and line limits.
`timescale 1ns / 1ps

package lsmt_pkg;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned LINE_W = 8;

  localparam logic [LINE_W-1:0] VISIBLE_LINES = 8'd144;
  localparam logic [LINE_W-1:0] TOTAL_LINES   = 8'd154;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_HBLANK_LEN = 2'd0;
  localparam logic [1:0] CFG_VBLANK_LEN = 2'd1;
  localparam logic [1:0] CFG_OAM_LEN    = 2'd2;
  localparam logic [1:0] CFG_XFER_LEN   = 2'd3;

  // mode codes as seen on the result word
  localparam logic [1:0] MODE_CODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_CODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_CODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_CODE_XFER   = 2'd3;

  typedef enum logic [3:0] {
    MODE_HBLANK = 4'b0001,
    MODE_VBLANK = 4'b0010,
    MODE_OAM    = 4'b0100,
    MODE_XFER   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] hblank_length;
    logic [CFG_W-1:0] vblank_line_length;
    logic [CFG_W-1:0] oam_scan_length;
    logic [CFG_W-1:0] transfer_length;
  } lsmt_cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic [LINE_W-1:0] scan_line;
    mode_t             scan_mode;
    logic              match_flag;
  } lsmt_state_t;

  typedef struct packed {
    logic              display_on;
    logic [LINE_W-1:0] line_compare;
    logic              hblank_irq_en;
    logic              vblank_irq_en;
    logic              oam_irq_en;
    logic              match_irq_en;
  } lsmt_in_t;

  typedef struct packed {
    logic [1:0]        mode_now;
    logic [LINE_W-1:0] line_now;
    logic              coincidence;
    logic              status_irq;
    logic              frame_irq;
    logic              line_strobe;
    logic              frame_strobe;
  } lsmt_out_t;

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    case (m)
      MODE_HBLANK: c = MODE_CODE_HBLANK;
      MODE_VBLANK: c = MODE_CODE_VBLANK;
      MODE_OAM:    c = MODE_CODE_OAM;
      MODE_XFER:   c = MODE_CODE_XFER;
      default:     c = MODE_CODE_HBLANK;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/lsmt_channels.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on lsmt_pkg for the payload structs.
`timescale 1ns / 1ps

interface lsmt_in_if import lsmt_pkg::*; ();
  logic     valid;
  logic     ready;
  lsmt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsmt_out_if import lsmt_pkg::*; ();
  logic      valid;
  logic      ready;
  lsmt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lsmt_cfg.sv
// Mode length registers, written through the plain configuration port.
// Depends on lsmt_pkg.
`timescale 1ns / 1ps

module lsmt_cfg import lsmt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output lsmt_cfg_t        cfg
);

  lsmt_cfg_t cfg_r;
  lsmt_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_HBLANK_LEN: cfg_nxt.hblank_length      = cfg_wdata;
        CFG_VBLANK_LEN: cfg_nxt.vblank_line_length = cfg_wdata;
        CFG_OAM_LEN:    cfg_nxt.oam_scan_length    = cfg_wdata;
        CFG_XFER_LEN:   cfg_nxt.transfer_length    = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hblank_length      <= 16'd204;
      cfg_r.vblank_line_length <= 16'd456;
      cfg_r.oam_scan_length    <= 16'd80;
      cfg_r.transfer_length    <= 16'd172;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/lsmt_core.sv
// One tick of the mode and line timing: next state and the result word.
// Pure combinational step; depends on lsmt_pkg.
`timescale 1ns / 1ps

module lsmt_core import lsmt_pkg::*; (
  input  lsmt_state_t state,
  input  lsmt_in_t    word,
  input  lsmt_cfg_t   cfg,
  output lsmt_state_t state_nxt,
  output lsmt_out_t   result
);

  logic [TICK_W-1:0] tick_inc;
  logic [CFG_W-1:0]  len;
  logic              done;
  logic [LINE_W-1:0] line_inc;
  logic [LINE_W-1:0] line_new;
  mode_t             mode_new;
  logic              stat;
  logic              frame;
  logic              lstb;
  logic              fstb;
  logic              match;

  // saturate the tick counter
  assign tick_inc = (state.tick_count == TICK_MAX) ? state.tick_count
                                                   : state.tick_count + 1'b1;
  assign line_inc = state.scan_line + 1'b1;

  always_comb begin
    case (state.scan_mode)
      MODE_HBLANK: len = cfg.hblank_length;
      MODE_VBLANK: len = cfg.vblank_line_length;
      MODE_OAM:    len = cfg.oam_scan_length;
      default:     len = cfg.transfer_length;
    endcase
  end

  assign done = (tick_inc >= len);

  always_comb begin
    line_new = state.scan_line;
    mode_new = state.scan_mode;
    stat     = 1'b0;
    frame    = 1'b0;
    lstb     = 1'b0;
    fstb     = 1'b0;
    case (state.scan_mode)
      MODE_HBLANK: begin
        if (done) begin
          line_new = line_inc;
          if (line_inc == VISIBLE_LINES) begin
            mode_new = MODE_VBLANK;
            fstb     = 1'b1;
            frame    = 1'b1;
            stat     = word.vblank_irq_en;
          end else begin
            mode_new = MODE_OAM;
          end
        end
      end
      MODE_VBLANK: begin
        if (done) begin
          if (line_inc >= TOTAL_LINES) begin
            line_new = '0;
            mode_new = MODE_OAM;
            stat     = word.oam_irq_en;
          end else begin
            line_new = line_inc;
          end
        end
      end
      MODE_OAM: begin
        if (done) mode_new = MODE_XFER;
      end
      default: begin
        if (done) begin
          mode_new = MODE_HBLANK;
          lstb     = 1'b1;
          stat     = word.hblank_irq_en;
        end
      end
    endcase
  end

  assign match = (line_new == word.line_compare);

  always_comb begin
    if (!word.display_on) begin
      // hold line zero in vblank, keep the match flag
      state_nxt.tick_count = '0;
      state_nxt.scan_line  = '0;
      state_nxt.scan_mode  = MODE_VBLANK;
      state_nxt.match_flag = state.match_flag;
      result.status_irq    = 1'b0;
      result.frame_irq     = 1'b0;
      result.line_strobe   = 1'b0;
      result.frame_strobe  = 1'b0;
    end else begin
      state_nxt.tick_count = done ? '0 : tick_inc;
      state_nxt.scan_line  = line_new;
      state_nxt.scan_mode  = mode_new;
      state_nxt.match_flag = match;
      result.status_irq    = stat | (match & word.match_irq_en);
      result.frame_irq     = frame;
      result.line_strobe   = lstb;
      result.frame_strobe  = fstb;
    end
    result.mode_now    = mode_code(state_nxt.scan_mode);
    result.line_now    = state_nxt.scan_line;
    result.coincidence = state_nxt.match_flag;
  end

endmodule

>>> rtl/lcd_scan_mode_timer.sv
// LCD scan mode timer: mode, line and interrupt timing, one word per tick.
// Accepted words pass the input register, then their results the result register.
// Throughput: one word per cycle unless the result stalls; lsmt_core is combinational.
// Reset (rst_n low, synchronous): both stages empty, hblank at line zero,
// tick count and match flag cleared, mode lengths 204/456/80/172.
`timescale 1ns / 1ps

module lcd_scan_mode_timer import lsmt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  lsmt_in_if.sink          in_ch,
  lsmt_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  lsmt_cfg_t   cfg;
  lsmt_state_t state_r;
  lsmt_state_t state_nxt;
  lsmt_in_t    in_q_r;
  lsmt_out_t   out_q_r;
  lsmt_out_t   result;
  logic        in_valid_r;
  logic        in_valid_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        advance;
  logic        take;

  lsmt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsmt_core u_core (
    .state     (state_r),
    .word      (in_q_r),
    .cfg       (cfg),
    .state_nxt (state_nxt),
    .result    (result)
  );

  // advance the held word when the result register is free or draining
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign take         = in_ch.valid && in_ch.ready;
  assign in_valid_nxt = take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      state_r.tick_count <= '0;
      state_r.scan_line  <= '0;
      state_r.scan_mode  <= MODE_HBLANK;
      state_r.match_flag <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take)    in_q_r  <= in_ch.data;
    if (advance) out_q_r <= result;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_q_r;

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.scan_line < TOTAL_LINES)
    else $error("scan line beyond last line");

  a_display_off: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !in_q_r.display_on |=>
      out_valid_r && out_q_r.mode_now == MODE_CODE_VBLANK && out_q_r.line_now == '0
      && !out_q_r.status_irq)
    else $error("display off did not park in vblank at line zero");

  a_frame_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_q_r.frame_irq |->
      out_q_r.frame_strobe && out_q_r.mode_now == MODE_CODE_VBLANK
      && out_q_r.line_now == VISIBLE_LINES)
    else $error("frame interrupt without entry to vblank");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ch.ready |=> $stable(state_r))
    else $error("state moved while result stalled");

endmodule
